@@ rtl/cfr_pkg.sv @@
package cfr_pkg;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h04;

  // Number of frame bytes that are not payload: start, id, command, length,
  // checksum high, checksum low, end.
  localparam int unsigned FRAME_OVERHEAD = 7;

  localparam logic [2:0] STATUS_GOOD       = 3'd0;
  localparam logic [2:0] STATUS_BAD_START  = 3'd1;
  localparam logic [2:0] STATUS_TOO_LONG   = 3'd2;
  localparam logic [2:0] STATUS_BAD_CHKSUM = 3'd3;
  localparam logic [2:0] STATUS_BAD_END    = 3'd4;

  // Decision of the parser for the byte now at the input.
  typedef struct packed {
    logic       needs_out;    // this position may give a result
    logic       emit;         // byte gives one result right away
    logic [2:0] status;
    logic [7:0] frame_id;
    logic [7:0] command;
    logic       drain_start;  // good frame with payload: read out the store
    logic [7:0] drain_len;
    logic       store_we;     // byte is a payload byte
    logic [7:0] store_slot;
    logic [7:0] store_data;
  } parse_t;

endpackage

@@ rtl/cfr_parser.sv @@
module cfr_parser #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output cfr_pkg::parse_t p
);

  localparam int unsigned PW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = ((PW > 8) ? PW : 8) + 2;

  logic [PW-1:0] frame_position;
  logic [PW-1:0] frame_position_next;
  logic [7:0]    held_id;
  logic [7:0]    held_command;
  logic [7:0]    held_length;
  logic [15:0]   running_sum;
  logic [15:0]   running_sum_next;
  logic [7:0]    checksum_high;

  logic [CW-1:0] pos_x;
  logic [CW-1:0] len_x;
  logic          hunting;
  logic          in_header;
  logic          too_long;
  logic          in_payload;
  logic          at_chk_high;
  logic          at_chk_low;
  logic          at_end;

  always_comb begin
    pos_x       = CW'(frame_position);
    len_x       = CW'(held_length);
    hunting     = (frame_position == '0);
    in_header   = !hunting && (pos_x < CW'(4));
    too_long    = !hunting && !in_header &&
                  ((len_x + CW'(cfr_pkg::FRAME_OVERHEAD)) > CW'(BUFFER_BYTES));
    in_payload  = !hunting && !in_header && !too_long && (pos_x < (len_x + CW'(4)));
    at_chk_high = !hunting && !in_header && !too_long && (pos_x == (len_x + CW'(4)));
    at_chk_low  = !hunting && !in_header && !too_long && (pos_x == (len_x + CW'(5)));
    at_end      = !hunting && !in_header && !too_long && !in_payload &&
                  !at_chk_high && !at_chk_low;
  end

  always_comb begin
    frame_position_next = frame_position + PW'(1);
    running_sum_next    = running_sum + 16'(rx_byte);

    p             = '0;
    p.needs_out   = hunting || too_long || at_chk_low || at_end;
    p.store_we    = in_payload;
    p.store_slot  = 8'(pos_x - CW'(4));
    p.store_data  = rx_byte;
    p.drain_len   = held_length;
    p.frame_id    = '0;
    p.command     = '0;
    p.status      = cfr_pkg::STATUS_GOOD;

    if (hunting) begin
      if (rx_byte != cfr_pkg::START_BYTE) begin
        p.emit              = 1'b1;
        p.status            = cfr_pkg::STATUS_BAD_START;
        frame_position_next = '0;
      end
    end else if (too_long) begin
      p.emit              = 1'b1;
      p.status            = cfr_pkg::STATUS_TOO_LONG;
      frame_position_next = '0;
    end else if (at_chk_low) begin
      if ({checksum_high, rx_byte} != running_sum) begin
        p.emit              = 1'b1;
        p.status            = cfr_pkg::STATUS_BAD_CHKSUM;
        frame_position_next = '0;
      end
    end else if (at_end) begin
      frame_position_next = '0;
      if (rx_byte != cfr_pkg::END_BYTE) begin
        p.emit   = 1'b1;
        p.status = cfr_pkg::STATUS_BAD_END;
      end else begin
        p.frame_id = held_id;
        p.command  = held_command;
        if (held_length == '0) begin
          p.emit = 1'b1;
        end else begin
          p.drain_start = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      held_id        <= '0;
      held_command   <= '0;
      held_length    <= '0;
      running_sum    <= '0;
      checksum_high  <= '0;
    end else if (accept) begin
      frame_position <= frame_position_next;
      if (hunting) begin
        running_sum <= '0;
      end
      if (in_header || in_payload) begin
        running_sum <= running_sum_next;
      end
      if (in_header && (pos_x == CW'(1))) begin
        held_id <= rx_byte;
      end
      if (in_header && (pos_x == CW'(2))) begin
        held_command <= rx_byte;
      end
      if (in_header && (pos_x == CW'(3))) begin
        held_length <= rx_byte;
      end
      if (at_chk_high) begin
        checksum_high <= rx_byte;
      end
    end
  end

endmodule

@@ rtl/cfr_emitter.sv @@
module cfr_emitter #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  cfr_pkg::parse_t p,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            drain_busy,
  output logic [2:0]      status,
  output logic [7:0]      frame_id,
  output logic [7:0]      command,
  output logic [5:0]      payload_length,
  output logic [7:0]      payload_byte,
  output logic [5:0]      byte_index,
  output logic            last
);

  localparam int unsigned DEPTH = BUFFER_BYTES - cfr_pkg::FRAME_OVERHEAD;
  localparam int unsigned SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    payload_store [DEPTH];
  logic [SW-1:0] drain_idx;
  logic [7:0]    drain_len;
  logic [7:0]    drain_id;
  logic [7:0]    drain_cmd;
  logic          load;
  logic          drain_last;

  assign load       = !out_valid || !out_stall;
  assign drain_last = ((8'(drain_idx) + 8'd1) == drain_len);

  // Payload write port.
  always_ff @(posedge clk) begin
    if (accept && p.store_we) begin
      payload_store[p.store_slot[SW-1:0]] <= p.store_data;
    end
  end

  // Control: result valid and drain sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      drain_busy <= 1'b0;
    end else begin
      if (load) begin
        if (drain_busy) begin
          out_valid <= 1'b1;
          if (drain_last) begin
            drain_busy <= 1'b0;
          end
        end else begin
          out_valid <= accept && p.emit;
        end
      end
      if (accept && p.drain_start) begin
        drain_busy <= 1'b1;
      end
    end
  end

  // Result payload and registered store read.
  always_ff @(posedge clk) begin
    if (load && drain_busy) begin
      status         <= cfr_pkg::STATUS_GOOD;
      frame_id       <= drain_id;
      command        <= drain_cmd;
      payload_length <= drain_len[5:0];
      payload_byte   <= payload_store[drain_idx];
      byte_index     <= 6'(drain_idx);
      last           <= drain_last;
      drain_idx      <= drain_idx + SW'(1);
    end else if (load && accept && p.emit) begin
      status         <= p.status;
      frame_id       <= p.frame_id;
      command        <= p.command;
      payload_length <= '0;
      payload_byte   <= '0;
      byte_index     <= '0;
      last           <= 1'b1;
    end
    if (accept && p.drain_start) begin
      drain_idx <= '0;
      drain_len <= p.drain_len;
      drain_id  <= p.frame_id;
      drain_cmd <= p.command;
    end
  end

endmodule

@@ rtl/command_frame_receiver_unit.sv @@
// Command frame receiver. Takes one received serial byte per request and
// recognizes frames of the form 0x01, id, command, length, payload, checksum
// high, checksum low, 0x04, where the checksum is the wrapping 16-bit sum of
// id, command, length and payload. A good frame delivers one result request
// per payload byte (or one when the payload is empty); any error delivers a
// single status request with last set and the receiver goes back to hunting
// for a start byte. A byte is taken in every cycle while results flow. A good
// frame with N payload bytes delivers its N results in turn from the single
// read port of the payload store; while that readout runs, the start byte of
// the next frame waits, so input resumes in the cycle after the last payload
// result is loaded. A byte that can give a result also waits while the output
// register holds a stalled result. The payload store holds
// BUFFER_BYTES - 7 bytes; a frame whose length does not fit is rejected on
// the byte after the length byte.
module command_frame_receiver_unit #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] frame_id,
  output logic [7:0] command,
  output logic [5:0] payload_length,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_index,
  output logic       last
);

  cfr_pkg::parse_t p;
  logic            in_accept;
  logic            drain_busy;

  // Hold the byte when it could collide with the store readout or would
  // overwrite a result that is still waiting downstream.
  assign in_stall  = (drain_busy && (p.needs_out || p.store_we)) ||
                     (out_valid && out_stall && p.needs_out);
  assign in_accept = in_valid && !in_stall;

  // Frame tracking: position, header fields, running sum.
  cfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .p       (p)
  );

  // Payload store, readout sequencer and output register.
  cfr_emitter #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_emitter (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .p              (p),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .drain_busy     (drain_busy),
    .status         (status),
    .frame_id       (frame_id),
    .command        (command),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last)
  );

  // A direct result never lands on top of a stalled result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_accept && p.emit) |-> !(out_valid && out_stall))
    else $error("direct result overwrites a waiting result");

  // No byte that gives a direct result, starts a readout or writes the store is taken during a running readout.
  a_no_emit_in_drain: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (p.emit || p.drain_start || p.store_we)) |-> !drain_busy)
    else $error("input byte taken during payload readout");

  // Error results are always single and final.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != cfr_pkg::STATUS_GOOD)) |-> last)
    else $error("error result without last");

  // A started readout shows up as busy in the next cycle.
  a_drain_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && p.drain_start) |=> drain_busy)
    else $error("payload readout did not start");

endmodule

@@ sim/tb_top.sv @@
module tb_top;

  localparam int unsigned BUF_BYTES      = 64;
  localparam int unsigned STORE_DEPTH    = BUF_BYTES - cfr_pkg::FRAME_OVERHEAD;
  localparam int unsigned HEADER_BYTES   = 4;     // start, id, command, length
  localparam int unsigned RANDOM_ITEMS   = 140;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned DIRECTED_COUNT = 27;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_id;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } frame_result_t;

  // One directed request; where typed is set, the byte gives exactly one result
  // with the listed status, id and command, empty payload fields and last set.
  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    logic [2:0] st;
    logic [7:0] id;
    logic [7:0] cmd;
  } rx_row_t;

  typedef enum {FK_GOOD, FK_BAD_CHKSUM, FK_BAD_END, FK_TOO_LONG, FK_NOISE, FK_CUT} frame_kind_e;
  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_e;

  localparam rx_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // hunting: anything but a start byte is rejected, both byte extremes
    '{8'h00, 1'b1, cfr_pkg::STATUS_BAD_START, 8'h00, 8'h00},
    '{8'hFF, 1'b1, cfr_pkg::STATUS_BAD_START, 8'h00, 8'h00},
    // empty payload, id and command at their maximum, checksum 0x01FE
    '{8'h01, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'hFF, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'hFF, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h01, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'hFE, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h04, 1'b1, cfr_pkg::STATUS_GOOD, 8'hFF, 8'hFF},
    // length one past what the store holds, rejected on the next byte
    '{8'h01, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h3A, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h5A, 1'b1, cfr_pkg::STATUS_TOO_LONG, 8'h00, 8'h00},
    // all-zero header, checksum low byte off by one
    '{8'h01, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h01, 1'b1, cfr_pkg::STATUS_BAD_CHKSUM, 8'h00, 8'h00},
    // good checksum, but the end byte is a start byte: reject it and do not
    // let it open a new frame
    '{8'h01, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h7F, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h80, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h00, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'hFF, 1'b0, cfr_pkg::STATUS_GOOD, 8'h00, 8'h00},
    '{8'h01, 1'b1, cfr_pkg::STATUS_BAD_END, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  logic [7:0] frame_id;
  logic [7:0] command;
  logic [5:0] payload_length;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;

  command_frame_receiver_unit #(.BUFFER_BYTES(BUF_BYTES)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .frame_id       (frame_id),
    .command        (command),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Frame parser state as the block should hold it.
  int unsigned   rx_pos = 0;
  logic [7:0]    held_id = '0;
  logic [7:0]    held_cmd = '0;
  logic [7:0]    held_len = '0;
  logic [15:0]   running_sum = '0;
  logic [7:0]    chk_hi = '0;
  logic [7:0]    payload_copy [STORE_DEPTH];

  frame_result_t frame_results_due [$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   random_bytes_sent = 0;

  // Advance the parser by one received byte; queue the results it gives
  // unless the caller supplies its own.
  task automatic decode_rx_byte(input logic [7:0] b, input bit record);
    int unsigned   len;
    bit            failed;
    logic [2:0]    fail_status;
    frame_result_t res;
    len = held_len;
    failed = 1'b0;
    fail_status = cfr_pkg::STATUS_GOOD;
    if (rx_pos == 0) begin
      if (b != cfr_pkg::START_BYTE) begin
        failed = 1'b1;
        fail_status = cfr_pkg::STATUS_BAD_START;
      end else begin
        running_sum = '0;
        rx_pos = 1;
      end
    end else if (rx_pos < HEADER_BYTES) begin
      if (rx_pos == 1) held_id = b;
      else if (rx_pos == 2) held_cmd = b;
      else held_len = b;
      running_sum = running_sum + b;
      rx_pos++;
    end else if (len + cfr_pkg::FRAME_OVERHEAD > BUF_BYTES) begin
      failed = 1'b1;
      fail_status = cfr_pkg::STATUS_TOO_LONG;
    end else if (rx_pos < HEADER_BYTES + len) begin
      payload_copy[rx_pos - HEADER_BYTES] = b;
      running_sum = running_sum + b;
      rx_pos++;
    end else if (rx_pos == HEADER_BYTES + len) begin
      chk_hi = b;
      rx_pos++;
    end else if (rx_pos == HEADER_BYTES + len + 1) begin
      if ({chk_hi, b} != running_sum) begin
        failed = 1'b1;
        fail_status = cfr_pkg::STATUS_BAD_CHKSUM;
      end else begin
        rx_pos++;
      end
    end else if (b == cfr_pkg::END_BYTE) begin
      rx_pos = 0;
      if (record && len == 0) begin
        res = '{cfr_pkg::STATUS_GOOD, held_id, held_cmd, 6'd0, 8'd0, 6'd0, 1'b1};
        frame_results_due.push_back(res);
      end else if (record) begin
        for (int unsigned i = 0; i < len; i++) begin
          res = '{cfr_pkg::STATUS_GOOD, held_id, held_cmd, 6'(len), payload_copy[i],
                  6'(i), (i + 1 == len)};
          frame_results_due.push_back(res);
        end
      end
    end else begin
      failed = 1'b1;
      fail_status = cfr_pkg::STATUS_BAD_END;
    end
    if (failed) begin
      rx_pos = 0;
      if (record) begin
        res = '{fail_status, 8'd0, 8'd0, 6'd0, 8'd0, 6'd0, 1'b1};
        frame_results_due.push_back(res);
      end
    end
  endtask

  // Offer one byte and hold it until accepted. The sender runs in bursts
  // separated by idle gaps; some bursts come with no gap at all.
  task automatic send_rx_byte(input logic [7:0] b, input bit typed, input frame_result_t fixed);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    decode_rx_byte(b, !typed);
    if (typed) frame_results_due.push_back(fixed);
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Go quiet on the input until every queued result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest are corrupted,
  // truncated or plain noise. A few frames are forced to the size extremes.
  task automatic send_random_frame(input int unsigned frame_no);
    logic [7:0]  fb [$];
    logic [15:0] sum;
    logic [7:0]  tail;
    int unsigned len;
    int unsigned pick;
    int unsigned keep;
    frame_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 55) kind = FK_GOOD;
    else if (pick < 65) kind = FK_BAD_CHKSUM;
    else if (pick < 75) kind = FK_BAD_END;
    else if (pick < 83) kind = FK_TOO_LONG;
    else if (pick < 93) kind = FK_NOISE;
    else kind = FK_CUT;
    if (frame_no <= 1) kind = FK_GOOD;
    if (frame_no == 4) kind = FK_TOO_LONG;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STORE_DEPTH) : $urandom_range(1, 8);
    if ($urandom_range(0, 5) == 0) len = 0;
    if (frame_no == 1) len = STORE_DEPTH;
    if (kind == FK_TOO_LONG) len = (frame_no == 4) ? 255 : $urandom_range(STORE_DEPTH + 1, 255);
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      fb.push_back(cfr_pkg::START_BYTE);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'(len));
      if (kind == FK_TOO_LONG) begin
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (len) fb.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        for (int i = 1; i < fb.size(); i++) sum = sum + fb[i];
        if (kind == FK_BAD_CHKSUM) sum = sum ^ (16'd1 << $urandom_range(0, 15));
        fb.push_back(sum[15:8]);
        fb.push_back(sum[7:0]);
        tail = cfr_pkg::END_BYTE;
        if (kind == FK_BAD_END) begin
          do tail = 8'($urandom_range(0, 255)); while (tail == cfr_pkg::END_BYTE);
        end
        fb.push_back(tail);
        if (kind == FK_CUT) begin
          keep = $urandom_range(1, fb.size() - 1);
          while (fb.size() > keep) fb.delete(fb.size() - 1);
        end
      end
    end
    foreach (fb[i]) send_rx_byte(fb[i], 1'b0, '0);
    random_bytes_sent += fb.size();
  endtask

  // Receiver stall: switch among a few stall patterns, each held for a
  // random stretch.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_phase_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(5, 60);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got status %0h",
                 $time, status);
        mismatch_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("status", 8'(want.status), 8'(status));
        check_field("frame_id", want.frame_id, frame_id);
        check_field("command", want.command, command);
        check_field("payload_length", 8'(want.payload_length), 8'(payload_length));
        check_field("payload_byte", want.payload_byte, payload_byte);
        check_field("byte_index", 8'(want.byte_index), 8'(byte_index));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned   frame_no;
    frame_result_t fixed;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
    frame_no = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      fixed = '{DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].cmd,
                6'd0, 8'd0, 6'd0, 1'b1};
      send_rx_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, fixed);
    end
    drain_results();

    while (random_bytes_sent < RANDOM_ITEMS) begin
      send_random_frame(frame_no);
      if (frame_no % 6 == 5) drain_results();
      frame_no++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
